[rtl/core/dpmc_pkg.sv]
// ----------------------------------------------------------------------------
// dpmc_pkg
// Shared types and constants of the digit pattern match counter.
// ----------------------------------------------------------------------------
package dpmc_pkg;

  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_COUNT_BITS  = 32;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_LIMIT   = 2'd2;

  localparam int PAT_W = 64;
  localparam int LEN_W = 5;
  localparam int LIM_W = 10;
  localparam logic [LIM_W-1:0] REPORT_LIMIT_RST = 10'd10;
  localparam logic [LIM_W-1:0] REPORT_MAX       = 10'd1023;

  // result kinds
  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;

  // result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic [31:0] start;
    logic [31:0] total;
    logic [32:0] first;
    logic        last;
  } dpmc_result_t;

  // results produced by one digit, in order r0 then r1
  typedef struct packed {
    logic [1:0]   n;
    dpmc_result_t r0;
    dpmc_result_t r1;
  } dpmc_push_t;

endpackage

[rtl/core/dpmc_window.sv]
// ----------------------------------------------------------------------------
// dpmc_window
// Window of recent digits and the parallel compare against the pattern.
// ----------------------------------------------------------------------------
module dpmc_window #(
  parameter int MAX_PATTERN = dpmc_pkg::DEF_MAX_PATTERN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       clear,
  input  logic [3:0]                 digit,
  input  logic [dpmc_pkg::PAT_W-1:0] pattern_digits,
  input  logic [dpmc_pkg::LEN_W-1:0] pattern_length,
  output logic                       hit
);
  import dpmc_pkg::*;

  logic [3:0]             win_r   [MAX_PATTERN];
  logic [3:0]             win_nxt [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match_l;

  // window after the new digit, newest first
  always_comb begin
    win_nxt[0] = digit;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // one compare chain per possible pattern length
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      match_l[l-1] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (pattern_digits[4*i +: 4] != win_nxt[l-1-i]) begin
          match_l[l-1] = 1'b0;
        end
      end
    end
  end

  // zero length and lengths beyond the window never hit
  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (LEN_W'(l) == pattern_length) begin
        hit = hit | match_l[l-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= 4'd0;
      end
    end else if (step) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= clear ? 4'd0 : win_nxt[k];
      end
    end
  end

endmodule

[rtl/core/dpmc_track.sv]
// ----------------------------------------------------------------------------
// dpmc_track
// Stream position, match counters and building of the result beats.
// ----------------------------------------------------------------------------
module dpmc_track #(
  parameter int COUNT_BITS = dpmc_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic                       end_flag,
  input  logic                       hit,
  input  logic [dpmc_pkg::LEN_W-1:0] pattern_length,
  input  logic [dpmc_pkg::LIM_W-1:0] report_limit,
  output dpmc_pkg::dpmc_push_t       push
);
  import dpmc_pkg::*;

  localparam int EXT_W = (COUNT_BITS > 33) ? COUNT_BITS : 33;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  fv_r, fv_nxt;
  logic [COUNT_BITS-1:0] ff_r, ff_nxt;
  logic [LIM_W-1:0]      rep_r, rep_nxt;

  logic                  found;
  logic                  report;
  logic [COUNT_BITS-1:0] len_ext;
  logic [COUNT_BITS-1:0] start;
  logic [EXT_W-1:0]      start_ext, cnt_ext, ff_ext;
  dpmc_result_t          rep_beat, sum_beat;

  always_comb begin
    len_ext = COUNT_BITS'(pattern_length);
    // no match before pattern_length digits of this stream have arrived
    found   = hit && (idx_r >= len_ext - COUNT_BITS'(1));
    start   = idx_r - (len_ext - COUNT_BITS'(1));

    cnt_nxt = (found && cnt_r != CNT_MAX) ? cnt_r + COUNT_BITS'(1) : cnt_r;
    fv_nxt  = fv_r | found;
    ff_nxt  = (found && !fv_r) ? start : ff_r;
    report  = found && (rep_r < report_limit);
    rep_nxt = (report && rep_r != REPORT_MAX) ? rep_r + LIM_W'(1) : rep_r;
    idx_nxt = (idx_r != CNT_MAX) ? idx_r + COUNT_BITS'(1) : idx_r;

    start_ext = EXT_W'(start);
    cnt_ext   = EXT_W'(cnt_nxt);
    ff_ext    = EXT_W'(ff_nxt);

    rep_beat.kind  = KIND_MATCH;
    rep_beat.start = start_ext[31:0];
    rep_beat.total = 32'd0;
    rep_beat.first = 33'd0;
    rep_beat.last  = !end_flag;

    sum_beat.kind  = KIND_SUMMARY;
    sum_beat.start = 32'd0;
    sum_beat.total = cnt_ext[31:0];
    sum_beat.first = fv_nxt ? ff_ext[32:0] : '1;
    sum_beat.last  = 1'b1;

    push.n  = step ? (2'(report) + 2'(end_flag)) : 2'd0;
    push.r0 = report ? rep_beat : sum_beat;
    push.r1 = sum_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
      fv_r  <= 1'b0;
      ff_r  <= '0;
      rep_r <= '0;
    end else if (step) begin
      if (end_flag) begin
        idx_r <= '0;
        cnt_r <= '0;
        fv_r  <= 1'b0;
        ff_r  <= '0;
        rep_r <= '0;
      end else begin
        idx_r <= idx_nxt;
        cnt_r <= cnt_nxt;
        fv_r  <= fv_nxt;
        ff_r  <= ff_nxt;
        rep_r <= rep_nxt;
      end
    end
  end

endmodule

[rtl/core/dpmc_outq.sv]
// ----------------------------------------------------------------------------
// dpmc_outq
// Result queue: takes up to two beats per cycle, sends one per cycle when pop_ready.
// ----------------------------------------------------------------------------
module dpmc_outq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dpmc_pkg::dpmc_push_t         push,
  input  logic                         pop_ready,
  output logic                         pop_valid,
  output dpmc_pkg::dpmc_result_t       head,
  output logic [dpmc_pkg::OQ_CW-1:0]   fill
);
  import dpmc_pkg::*;

  dpmc_result_t      q_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  wp_r, wp_nxt;
  logic [OQ_AW-1:0]  rp_r, rp_nxt;
  logic [OQ_CW-1:0]  cnt_r, cnt_nxt;
  logic              pop;

  always_comb begin
    pop       = (cnt_r != '0) && pop_ready;
    pop_valid = (cnt_r != '0);
    head      = q_r[rp_r];
    fill      = cnt_r;
    wp_nxt    = wp_r + OQ_AW'(push.n);
    rp_nxt    = pop ? rp_r + OQ_AW'(1) : rp_r;
    cnt_nxt   = cnt_r + OQ_CW'(push.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wp_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wp_r + OQ_AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/core/digit_pattern_match_counter.sv]
// ----------------------------------------------------------------------------
// digit_pattern_match_counter
// Counts overlapping occurrences of a digit pattern in a digit stream.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                              tuser        tlast
//  in_      in   [3:0] digit                        -            stream_end
//  out_     out  [31:0] match_start,                 result_kind  run_last
//                [63:32] match_total,
//                [96:64] first_match_res
//  cfg_     in   cfg_index selects register, cfg_data holds value (always ready)
//
//  One digit is accepted per cycle while in_tready is high; it is held in the input
//  register, and its result beats enter the 8-entry result queue the next edge.
//  The output sends one beat per cycle, so a run of digits that each give two
//  beats, or a stalled out_tready, throttles in_tready through the queue fill.
//  Reset is synchronous; no clearing pass, the block is ready right after it.
// ----------------------------------------------------------------------------
module digit_pattern_match_counter #(
  parameter int MAX_PATTERN = dpmc_pkg::DEF_MAX_PATTERN,
  parameter int COUNT_BITS  = dpmc_pkg::DEF_COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input beats
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dpmc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [3:0] digit
  input  logic                             in_tlast,   // stream_end
  // result beats
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dpmc_pkg::OUT_TDATA_W-1:0] out_tdata,  // match_start, match_total,
                                                       // first_match_res
  output logic                             out_tuser,  // result_kind
  output logic                             out_tlast,  // run_last
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpmc_pkg::PAT_W-1:0]       cfg_data
);
  import dpmc_pkg::*;

  logic [PAT_W-1:0]  pat_r;
  logic [LEN_W-1:0]  len_r;
  logic [LIM_W-1:0]  lim_r;

  logic              s1_valid_r;
  logic [3:0]        s1_digit_r;
  logic              s1_end_r;

  logic              in_acc;
  logic              hit;
  dpmc_push_t        push;
  dpmc_result_t      head;
  logic [OQ_CW-1:0]  fill;
  logic [OQ_CW:0]    reserved;

  // keep room for two beats from the digit in flight and two from a new one
  always_comb begin
    reserved  = {1'b0, fill} + (s1_valid_r ? (OQ_CW+1)'(2) : '0);
    in_tready = (reserved <= (OQ_CW+1)'(OQ_DEPTH - 2));
    in_acc    = in_tvalid && in_tready;
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= '0;
      lim_r <= REPORT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_DIGITS: pat_r <= cfg_data;
        REG_PATTERN_LENGTH: len_r <= cfg_data[LEN_W-1:0];
        REG_REPORT_LIMIT:   lim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_digit_r <= in_tdata[3:0];
      s1_end_r   <= in_tlast;
    end
  end

  dpmc_window #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_valid_r),
    .clear          (s1_end_r),
    .digit          (s1_digit_r),
    .pattern_digits (pat_r),
    .pattern_length (len_r),
    .hit            (hit)
  );

  dpmc_track #(
    .COUNT_BITS (COUNT_BITS)
  ) u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (s1_valid_r),
    .end_flag       (s1_end_r),
    .hit            (hit),
    .pattern_length (len_r),
    .report_limit   (lim_r),
    .push           (push)
  );

  dpmc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .head      (head),
    .fill      (fill)
  );

  always_comb begin
    out_tdata = {(OUT_TDATA_W - 97)'(0), head.first, head.total, head.start};
    out_tuser = head.kind;
    out_tlast = head.last;
  end

endmodule

[verif/dpmc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpmc_checker
// Watches the digit, result and register channels of the match counter. Each
// accepted digit is run through a local scan model that produces the match
// reports and summaries it should cause. Result beats are compared in order
// against those.
// ----------------------------------------------------------------------------
module dpmc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [dpmc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [dpmc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tuser,
  input  logic                             out_tlast,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [dpmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpmc_pkg::PAT_W-1:0]       cfg_data,
  output int                               mismatches,
  output int                               awaiting
);
  import dpmc_pkg::*;

  // register copies
  logic [PAT_W-1:0] pat_reg;
  logic [LEN_W-1:0] len_reg;
  logic [LIM_W-1:0] lim_reg;

  // scan state of the current stream
  logic [3:0]       recent [DEF_MAX_PATTERN];
  logic [31:0]      pos;
  logic [31:0]      hits;
  logic             first_seen;
  logic [31:0]      first_pos;
  logic [LIM_W-1:0] reported;

  dpmc_result_t awaited_beats[$];

  task automatic clear_stream();
    int i;
    for (i = 0; i < DEF_MAX_PATTERN; i++) recent[i] = 4'd0;
    pos = '0;
    hits = '0;
    first_seen = 1'b0;
    first_pos = '0;
    reported = '0;
  endtask

  task automatic add_beat(input dpmc_result_t r);
    awaited_beats.insert(awaited_beats.size(), r);
  endtask

  function automatic bit window_hit();
    int unsigned n;
    int unsigned i;
    n = 32'(len_reg);
    if (n == 0 || n > DEF_MAX_PATTERN) return 1'b0;
    // oldest digit of the window lines up with the first pattern digit
    for (i = 0; i < n; i++)
      if (pat_reg[4*i +: 4] != recent[n-1-i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic scan_digit(input logic [3:0] d, input logic stop);
    dpmc_result_t r;
    logic [31:0] here;
    logic [31:0] start;
    int i;
    here = pos;
    for (i = DEF_MAX_PATTERN - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = d;
    if (len_reg >= 1 && here >= 32'(len_reg) - 32'd1 && window_hit()) begin
      start = here - (32'(len_reg) - 32'd1);
      if (hits != '1) hits = hits + 32'd1;
      if (!first_seen) begin
        first_seen = 1'b1;
        first_pos = start;
      end
      if (reported < lim_reg) begin
        r = '0;
        r.kind = KIND_MATCH;
        r.start = start;
        r.last = !stop;
        add_beat(r);
        if (reported != REPORT_MAX) reported = reported + LIM_W'(1);
      end
    end
    if (pos != '1) pos = pos + 32'd1;
    if (stop) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.total = hits;
      r.first = first_seen ? {1'b0, first_pos} : '1;
      r.last = 1'b1;
      add_beat(r);
      clear_stream();
    end
  endtask

  task automatic check_beat();
    dpmc_result_t got;
    dpmc_result_t want;
    bit bad;
    got.kind = out_tuser;
    got.start = out_tdata[31:0];
    got.total = out_tdata[63:32];
    got.first = out_tdata[96:64];
    got.last = out_tlast;
    if (awaited_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected beat kind %0d start %0d total %0d first %0h last %0d",
                 $time, got.kind, got.start, got.total, got.first, got.last);
    end else begin
      want = awaited_beats.pop_front();
      bad = (got.kind != want.kind) || (got.start != want.start) ||
            (got.total != want.total) || (got.first != want.first) ||
            (got.last != want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: beat mismatch exp/got: kind %0d/%0d start %0d/%0d ",
                 $time, want.kind, got.kind, want.start, got.start);
          $display("total %0d/%0d first %0h/%0h last %0d/%0d",
                   want.total, got.total, want.first, got.first, want.last, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_reg = '0;
      len_reg = '0;
      lim_reg = REPORT_LIMIT_RST;
      clear_stream();
      awaited_beats.delete();
      mismatches = 0;
    end else begin
      // beats leaving now were caused by digits taken at earlier edges
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) scan_digit(in_tdata[3:0], in_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_DIGITS: pat_reg = cfg_data;
          REG_PATTERN_LENGTH: len_reg = cfg_data[LEN_W-1:0];
          REG_REPORT_LIMIT:   lim_reg = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
    awaiting = awaited_beats.size();
  end

endmodule

[verif/tb_digit_pattern_match_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_digit_pattern_match_counter
// Drives digit streams into the match counter under a series of pattern,
// length and report limit settings: a short directed set of corner streams,
// then random streams seeded with pattern copies. Both channels idle at
// random; in two phases the result side stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_digit_pattern_match_counter;
  import dpmc_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [PAT_W-1:0]       cfg_data;

  int mismatches;
  int awaiting;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  logic [3:0] run_q[$];

  always #10 clk = ~clk;

  digit_pattern_match_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  dpmc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  function automatic logic [3:0] any_digit();
    return ($urandom_range(0, 24) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
  endfunction

  // lower valid, then wait until every expected beat is out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_setup(input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len,
                            input logic [LIM_W-1:0] lim);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    drain();
    write_reg(REG_PATTERN_DIGITS, pat);
    // unused upper bits are sometimes set to check that they are ignored
    write_reg(REG_PATTERN_LENGTH, $urandom_range(0, 1) ? {junk[63:LEN_W], len} : 64'(len));
    write_reg(REG_REPORT_LIMIT, $urandom_range(0, 1) ? {junk[63:LIM_W], lim} : 64'(lim));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_digit(input logic [3:0] d, input logic stop);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, d};
    in_tlast  <= stop;
    do @(posedge clk); while (!in_tready);
  endtask

  // short stream from packed nibbles, first digit in the low nibble
  task automatic send_seq(input logic [63:0] digits, input int n, input bit close);
    int i;
    for (i = 0; i < n; i++) send_digit(digits[4*i +: 4], close && (i == n - 1));
  endtask

  task automatic send_run(input bit close);
    int i;
    for (i = 0; i < run_q.size(); i++)
      send_digit(run_q[i], close && (i == run_q.size() - 1));
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = 300;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [63:0] cur_pat;
    logic [4:0]  cur_len;
    logic [9:0]  cur_lim;
    int          ph;
    int          i;
    int          count;
    int          slen;
    int          plen;
    bit          narrow;
    bit          close;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty pattern straight out of reset
    send_seq(64'h321, 3, 1'b1);
    // overlapping hits, last one on the closing digit
    load_setup(64'h121, 3, 10);
    send_seq(64'h12121, 5, 1'b1);
    // digits above nine, report limit of one
    load_setup(64'hFA, 2, 1);
    send_seq(64'hFAFFA, 5, 1'b1);
    // zero pattern must not match the cleared window before enough digits came
    load_setup(64'h00, 2, 1023);
    send_seq(64'h0, 1, 1'b1);
    send_seq(64'h0, 3, 1'b1);
    // pattern longer than the window
    load_setup(64'h0, 17, 10);
    send_seq(64'h0, 2, 1'b1);
    // no reports allowed, summary only
    load_setup(64'h5, 1, 0);
    send_seq(64'h55, 2, 1'b1);

    for (ph = 0; ph < 10; ph++) begin
      for (i = 0; i < 16; i++) cur_pat[4*i +: 4] = any_digit();
      if (ph == 0) cur_pat = '1;
      if (ph == 3) cur_pat = '0;
      if (ph == 9) cur_pat = {$urandom, $urandom};
      cur_len = (ph == 0) ? 5'd16 : (ph == 5) ? 5'd31 : (ph == 8) ? 5'd0 :
                5'($urandom_range(1, 5));
      cur_lim = (ph == 0) ? 10'd1023 : (ph == 2) ? 10'd0 : (ph == 4) ? 10'd1 :
                ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023)) :
                10'($urandom_range(2, 12));
      load_setup(cur_pat, cur_len, cur_lim);
      calm = (ph == 3 || ph == 7);
      plen = (cur_len == 5'd0) ? 2 : (cur_len > 5'd16) ? 16 : int'(cur_len);
      count = 0;
      while (count < 175) begin
        run_q.delete();
        slen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 30);
        narrow = ($urandom_range(0, 3) == 0);
        while (run_q.size() < slen) begin
          if ($urandom_range(0, 2) == 0) begin
            for (i = 0; i < plen; i++) run_q.insert(run_q.size(), cur_pat[4*i +: 4]);
          end else if (narrow) begin
            run_q.insert(run_q.size(), cur_pat[4*$urandom_range(0, plen - 1) +: 4]);
          end else begin
            run_q.insert(run_q.size(), any_digit());
          end
        end
        if ((ph == 1 || ph == 6) && count < 60 && count + run_q.size() >= 60)
          hold_req = 1'b1;
        // the last stream of a phase is sometimes left open across the register change
        close = (count + run_q.size() < 175) || ($urandom_range(0, 2) != 0);
        send_run(close);
        count += run_q.size();
      end
    end
    calm = 1'b0;

    drain();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[digit_pattern_match_counter.f]
rtl/core/dpmc_pkg.sv
rtl/core/dpmc_window.sv
rtl/core/dpmc_track.sv
rtl/core/dpmc_outq.sv
rtl/core/digit_pattern_match_counter.sv
verif/dpmc_checker.sv
verif/tb_digit_pattern_match_counter.sv
